// ===== rtl/cnvtr_pkg.sv =====
// Shared types, sizes and fixed-point helpers for the convolution training engine.
// No dependencies; imported by the front end, queue, back end and top level.
package cnvtr_pkg;

   localparam int MAX_WIDTH        = 32;
   localparam int MAX_HEIGHT       = 32;
   localparam int MAX_KERNEL       = 5;
   localparam int MAX_IN_CHANNELS  = 4;
   localparam int MAX_OUT_CHANNELS = 8;

   localparam int PLANE_DEPTH  = MAX_WIDTH * MAX_HEIGHT * MAX_IN_CHANNELS;
   localparam int KERNEL_DEPTH = MAX_KERNEL * MAX_KERNEL * MAX_IN_CHANNELS * MAX_OUT_CHANNELS;
   localparam int PA_W         = $clog2(PLANE_DEPTH);
   localparam int KA_W         = $clog2(KERNEL_DEPTH);
   localparam int ACC_W        = 72;
   localparam int WIDE_W       = 73;
   localparam int FIFO_DEPTH   = 2;

   localparam logic [5:0]  RESET_WIDTH  = 6'd32;
   localparam logic [5:0]  RESET_HEIGHT = 6'd32;
   localparam logic [2:0]  RESET_KERNEL = 3'd3;
   localparam logic [2:0]  RESET_NIN    = 3'd1;
   localparam logic [3:0]  RESET_NOUT   = 4'd1;
   localparam logic [15:0] RESET_RATE   = 16'd655;

   typedef enum logic [2:0] {
      OP_WR_WEIGHT   = 3'd0,
      OP_WR_INPUT    = 3'd1,
      OP_RD_OUTPUT   = 3'd2,
      OP_ADD_GRAD    = 3'd3,
      OP_RD_CLR_GRAD = 3'd4,
      OP_TRAIN       = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_RANGE  = 2'd1,
      ST_KERNEL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      REG_WIDTH  = 3'd0,
      REG_HEIGHT = 3'd1,
      REG_KERNEL = 3'd2,
      REG_NIN    = 3'd3,
      REG_NOUT   = 3'd4,
      REG_RATE   = 3'd5
   } reg_type;

   typedef struct packed {
      logic [5:0]  w;
      logic [5:0]  h;
      logic [2:0]  k;
      logic [2:0]  nin;
      logic [3:0]  nout;
      logic [15:0] rate;
      logic [4:0]  kk;
      logic [7:0]  kstep;
      logic [10:0] wh;
      logic [10:0] oplane;
      logic [5:0]  oh;
      logic [9:0]  nw;
      logic [12:0] ni;
      logic [13:0] no;
      logic        kbig;
   } cfg_type;

   typedef struct packed {
      logic [2:0]         op;
      logic [12:0]        index;
      logic signed [31:0] value;
      logic [1:0]         status;
   } cmd_type;

   localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'(32'sh7fffffff);
   localparam logic signed [WIDE_W-1:0] SAT_LO = WIDE_W'(32'sh80000000);
   localparam logic signed [WIDE_W-1:0] HALF   = WIDE_W'(32'sh00008000);

   function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [31:0] r;
      if (v > SAT_HI) r = 32'sh7fffffff;
      else if (v < SAT_LO) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   // Q15.16 round to nearest, ties up, then saturate
   function automatic logic signed [31:0] rnd_sat(input logic signed [WIDE_W-1:0] p);
      logic signed [WIDE_W-1:0] s;
      s = p + HALF;
      return sat32(s >>> 16);
   endfunction

   function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      return sat32(WIDE_W'(a) + WIDE_W'(b));
   endfunction

endpackage

// ===== rtl/cnvtr_if.sv =====
// Channel interfaces: request, response and register-write channels.
// Depends on nothing; payload widths follow the field list.
interface cnvtr_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         opcode;
   logic [12:0]        index;
   logic signed [31:0] value;
   modport source(output valid, opcode, index, value, input ready);
   modport sink(input valid, opcode, index, value, output ready);
endinterface

interface cnvtr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_value;
   logic [1:0]         status;
   modport source(output valid, result_value, status, input ready);
   modport sink(input valid, result_value, status, output ready);
endinterface

interface cnvtr_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/cnvtr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cnvtr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 800
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/cnvtr_front.sv =====
// Front end: configuration registers, derived sizes, request classification.
// Depends on cnvtr_pkg and cnvtr_if.
module cnvtr_front (
   input  logic              clock,
   input  logic              reset,
   cnvtr_req_if.sink         req_ch,
   cnvtr_csr_if.sink         csr_ch,
   output logic              push_valid,
   input  logic              push_ready,
   output cnvtr_pkg::cmd_type push_data,
   output cnvtr_pkg::cfg_type cfg
);
   import cnvtr_pkg::*;

   logic [5:0]  w_ff, w_in, h_ff, h_in;
   logic [2:0]  k_ff, k_in, nin_ff, nin_in;
   logic [3:0]  nout_ff, nout_in;
   logic [15:0] rate_ff, rate_in;
   logic        hold_ff;
   cfg_type     cfg_ff, cfg_in;
   logic        csr_fire;
   logic [5:0]  ow;
   logic [1:0]  st;

   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid;

   always_comb begin
      w_in    = w_ff;
      h_in    = h_ff;
      k_in    = k_ff;
      nin_in  = nin_ff;
      nout_in = nout_ff;
      rate_in = rate_ff;
      if (csr_fire) begin
         unique case (csr_ch.index)
            REG_WIDTH: begin
               w_in = csr_ch.data[5:0];
               if (w_in == 6'd0) w_in = 6'd1;
               else if (w_in > 6'(MAX_WIDTH)) w_in = 6'(MAX_WIDTH);
            end
            REG_HEIGHT: begin
               h_in = csr_ch.data[5:0];
               if (h_in == 6'd0) h_in = 6'd1;
               else if (h_in > 6'(MAX_HEIGHT)) h_in = 6'(MAX_HEIGHT);
            end
            REG_KERNEL: begin
               k_in = csr_ch.data[2:0];
               if (k_in == 3'd0) k_in = 3'd1;
               else if (k_in > 3'(MAX_KERNEL)) k_in = 3'(MAX_KERNEL);
            end
            REG_NIN: begin
               nin_in = csr_ch.data[2:0];
               if (nin_in == 3'd0) nin_in = 3'd1;
               else if (nin_in > 3'(MAX_IN_CHANNELS)) nin_in = 3'(MAX_IN_CHANNELS);
            end
            REG_NOUT: begin
               nout_in = csr_ch.data[3:0];
               if (nout_in == 4'd0) nout_in = 4'd1;
               else if (nout_in > 4'(MAX_OUT_CHANNELS)) nout_in = 4'(MAX_OUT_CHANNELS);
            end
            REG_RATE: rate_in = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      ow            = w_ff - 6'(k_ff) + 6'd1;
      cfg_in.w      = w_ff;
      cfg_in.h      = h_ff;
      cfg_in.k      = k_ff;
      cfg_in.nin    = nin_ff;
      cfg_in.nout   = nout_ff;
      cfg_in.rate   = rate_ff;
      cfg_in.kk     = 5'(k_ff) * 5'(k_ff);
      cfg_in.kstep  = 8'(nout_ff) * 8'(cfg_in.kk);
      cfg_in.wh     = 11'(w_ff) * 11'(h_ff);
      cfg_in.oh     = h_ff - 6'(k_ff) + 6'd1;
      cfg_in.oplane = 11'(ow) * 11'(cfg_in.oh);
      cfg_in.nw     = 10'(nin_ff) * 10'(cfg_in.kstep);
      cfg_in.ni     = 13'(cfg_in.wh) * 13'(nin_ff);
      cfg_in.no     = 14'(cfg_in.oplane) * 14'(nout_ff);
      cfg_in.kbig   = (6'(k_ff) > w_ff) || (6'(k_ff) > h_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff    <= RESET_WIDTH;
         h_ff    <= RESET_HEIGHT;
         k_ff    <= RESET_KERNEL;
         nin_ff  <= RESET_NIN;
         nout_ff <= RESET_NOUT;
         rate_ff <= RESET_RATE;
         hold_ff <= 1'b1;
      end else begin
         w_ff    <= w_in;
         h_ff    <= h_in;
         k_ff    <= k_in;
         nin_ff  <= nin_in;
         nout_ff <= nout_in;
         rate_ff <= rate_in;
         hold_ff <= csr_fire;
      end
      cfg_ff <= cfg_in;
   end

   // kernel-size check, then range check per opcode
   always_comb begin
      st = ST_OK;
      if (cfg_ff.kbig) begin
         st = ST_KERNEL;
      end else begin
         unique case (req_ch.opcode)
            OP_WR_WEIGHT:
               if (14'(req_ch.index) >= 14'(cfg_ff.nw)) st = ST_RANGE;
            OP_WR_INPUT, OP_RD_CLR_GRAD:
               if (14'(req_ch.index) >= 14'(cfg_ff.ni)) st = ST_RANGE;
            OP_RD_OUTPUT, OP_ADD_GRAD:
               if (14'(req_ch.index) >= cfg_ff.no) st = ST_RANGE;
            default: st = ST_OK;
         endcase
      end
   end

   assign req_ch.ready     = push_ready && !hold_ff;
   assign push_valid       = req_ch.valid && !hold_ff;
   assign push_data.op     = req_ch.opcode;
   assign push_data.index  = req_ch.index;
   assign push_data.value  = req_ch.value;
   assign push_data.status = st;
   assign cfg              = cfg_ff;
endmodule

// ===== rtl/cnvtr_fifo.sv =====
// Two-entry command queue between front end and execution back end.
// Depends on cnvtr_pkg.
module cnvtr_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  cnvtr_pkg::cmd_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output cnvtr_pkg::cmd_type pop_data
);
   import cnvtr_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);

   cmd_type            mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   logic               push_fire, pop_fire;

   assign push_ready = count_ff != (PTR_W+1)'(FIFO_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_fire ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_fire ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push_fire) - (PTR_W+1)'(pop_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_fire) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// ===== rtl/cnvtr_back.sv =====
// Back end: store clearing, index decomposition, tap sequencer, MAC/update pipeline.
// Depends on cnvtr_pkg, cnvtr_if and cnvtr_ram.
module cnvtr_back (
   input  logic               clock,
   input  logic               reset,
   input  cnvtr_pkg::cfg_type cfg,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  cnvtr_pkg::cmd_type pop_data,
   cnvtr_rsp_if.source        rsp_ch
);
   import cnvtr_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_DIV_OC, S_DIV_COL, S_SETUP, S_RUN, S_DRAIN, S_RESP
   } state_type;

   state_type          state_ff, state_in;
   logic [PA_W-1:0]    clr_ff, clr_in;
   logic [2:0]         op_ff, op_in;
   logic signed [31:0] val_ff, val_in;
   logic [12:0]        rem_ff, rem_in;
   logic [2:0]         oc_ff, oc_in;
   logic [4:0]         col_ff, col_in;
   logic [2:0]         r_ff, r_in, c_ff, c_in, ci_ff, ci_in;
   logic [KA_W-1:0]    wi_ff, wi_in, kb_ff, kb_in;
   logic [PA_W-1:0]    xcol_ff, xcol_in, ichan_ff, ichan_in;
   logic signed [31:0] res_ff, res_in;
   logic [1:0]         st_ff, st_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic               issue, last;
   logic [PA_W-1:0]    xi_s0;
   logic               s1_v_ff, s2_v_ff;
   logic [KA_W-1:0]    s1_wi_ff, s2_wi_ff;
   logic [PA_W-1:0]    s1_xi_ff, s2_xi_ff;
   logic signed [31:0] s2_w_ff, s2_ig_ff, s2_wg_ff;
   logic signed [63:0] pa_ff, pb_ff;
   logic signed [31:0] mul_a, mul_b;
   logic signed [ACC_W-1:0] acc_ff;

   logic               w_we, x_we, ig_we, wg_we;
   logic [KA_W-1:0]    w_wa, wg_wa;
   logic [PA_W-1:0]    x_wa, ig_wa;
   logic [31:0]        w_wd, x_wd, ig_wd, wg_wd;
   logic [31:0]        w_rd, x_rd, ig_rd, wg_rd;

   assign pop_ready = state_ff == S_IDLE;
   assign issue     = state_ff == S_RUN;
   assign xi_s0     = xcol_ff + PA_W'(r_ff);

   always_comb begin
      priority case (op_ff)
         OP_RD_CLR_GRAD: last = 1'b1;
         OP_TRAIN:       last = wi_ff == KA_W'(KERNEL_DEPTH - 1);
         default:        last = (r_ff == cfg.k - 3'd1) && (c_ff == cfg.k - 3'd1)
                                && (ci_ff == cfg.nin - 3'd1);
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      rem_in        = rem_ff;
      oc_in         = oc_ff;
      col_in        = col_ff;
      r_in          = r_ff;
      c_in          = c_ff;
      ci_in         = ci_ff;
      wi_in         = wi_ff;
      kb_in         = kb_ff;
      xcol_in       = xcol_ff;
      ichan_in      = ichan_ff;
      res_in        = res_ff;
      st_in         = st_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + PA_W'(1);
            if (clr_ff == PA_W'(PLANE_DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (pop_valid) begin
               op_in  = pop_data.op;
               val_in = pop_data.value;
               st_in  = pop_data.status;
               res_in = '0;
               rem_in = pop_data.index;
               oc_in  = '0;
               col_in = '0;
               r_in   = '0;
               c_in   = '0;
               ci_in  = '0;
               wi_in  = '0;
               xcol_in = pop_data.index[PA_W-1:0];
               if (pop_data.status != ST_OK) begin
                  state_in = S_RESP;
               end else begin
                  unique case (pop_data.op)
                     OP_RD_OUTPUT, OP_ADD_GRAD: state_in = S_DIV_OC;
                     OP_RD_CLR_GRAD, OP_TRAIN:  state_in = S_RUN;
                     default:                   state_in = S_RESP;
                  endcase
               end
            end
         end
         S_DIV_OC: begin
            if (rem_ff >= 13'(cfg.oplane)) begin
               rem_in = rem_ff - 13'(cfg.oplane);
               oc_in  = oc_ff + 3'd1;
            end else begin
               state_in = S_DIV_COL;
            end
         end
         S_DIV_COL: begin
            if (rem_ff >= 13'(cfg.oh)) begin
               rem_in = rem_ff - 13'(cfg.oh);
               col_in = col_ff + 5'd1;
            end else begin
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            kb_in    = KA_W'(oc_ff) * KA_W'(cfg.kk);
            wi_in    = kb_in;
            ichan_in = PA_W'(col_ff) * PA_W'(cfg.h) + PA_W'(rem_ff);
            xcol_in  = ichan_in;
            state_in = S_RUN;
         end
         S_RUN: begin
            if (op_ff == OP_TRAIN) begin
               wi_in = wi_ff + KA_W'(1);
            end else if (r_ff != cfg.k - 3'd1) begin
               r_in  = r_ff + 3'd1;
               wi_in = wi_ff + KA_W'(1);
            end else if (c_ff != cfg.k - 3'd1) begin
               r_in    = '0;
               c_in    = c_ff + 3'd1;
               wi_in   = wi_ff + KA_W'(1);
               xcol_in = xcol_ff + PA_W'(cfg.h);
            end else begin
               r_in     = '0;
               c_in     = '0;
               ci_in    = ci_ff + 3'd1;
               kb_in    = kb_ff + KA_W'(cfg.kstep);
               wi_in    = kb_in;
               ichan_in = ichan_ff + PA_W'(cfg.wh);
               xcol_in  = ichan_in;
            end
            if (last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (!s1_v_ff && !s2_v_ff) begin
               priority case (op_ff)
                  OP_RD_OUTPUT:   res_in = rnd_sat(WIDE_W'(acc_ff));
                  OP_RD_CLR_GRAD: res_in = s2_ig_ff;
                  default:        res_in = '0;
               endcase
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_ff;
               rsp_status_in = st_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      val_ff        <= val_in;
      rem_ff        <= rem_in;
      oc_ff         <= oc_in;
      col_ff        <= col_in;
      r_ff          <= r_in;
      c_ff          <= c_in;
      ci_ff         <= ci_in;
      wi_ff         <= wi_in;
      kb_ff         <= kb_in;
      xcol_ff       <= xcol_in;
      ichan_ff      <= ichan_in;
      res_ff        <= res_in;
      st_ff         <= st_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // tap pipeline: issue -> read data -> product -> write back / accumulate
   always_comb begin
      priority case (op_ff)
         OP_RD_OUTPUT: mul_a = $signed(w_rd);
         OP_TRAIN:     mul_a = $signed({16'b0, cfg.rate});
         default:      mul_a = val_ff;
      endcase
      priority case (op_ff)
         OP_RD_OUTPUT: mul_b = $signed(x_rd);
         OP_TRAIN:     mul_b = $signed(wg_rd);
         default:      mul_b = $signed(w_rd);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= issue;
         s2_v_ff <= s1_v_ff;
      end
      s1_wi_ff <= wi_ff;
      s1_xi_ff <= xi_s0;
      if (s1_v_ff) begin
         s2_wi_ff <= s1_wi_ff;
         s2_xi_ff <= s1_xi_ff;
         s2_w_ff  <= $signed(w_rd);
         s2_ig_ff <= $signed(ig_rd);
         s2_wg_ff <= $signed(wg_rd);
         pa_ff    <= mul_a * mul_b;
         pb_ff    <= val_ff * $signed(x_rd);
      end
      if (state_ff == S_SETUP) begin
         acc_ff <= '0;
      end else if (s2_v_ff && op_ff == OP_RD_OUTPUT) begin
         acc_ff <= acc_ff + ACC_W'(pa_ff);
      end
   end

   always_comb begin
      w_we  = 1'b0;  w_wa  = '0;  w_wd  = '0;
      x_we  = 1'b0;  x_wa  = '0;  x_wd  = '0;
      ig_we = 1'b0;  ig_wa = '0;  ig_wd = '0;
      wg_we = 1'b0;  wg_wa = '0;  wg_wd = '0;
      if (state_ff == S_CLEAR) begin
         w_we  = clr_ff < PA_W'(KERNEL_DEPTH);
         w_wa  = clr_ff[KA_W-1:0];
         wg_we = w_we;
         wg_wa = w_wa;
         x_we  = 1'b1;
         x_wa  = clr_ff;
         ig_we = 1'b1;
         ig_wa = clr_ff;
      end else if (state_ff == S_IDLE) begin
         if (pop_valid && pop_data.status == ST_OK) begin
            w_we = pop_data.op == OP_WR_WEIGHT;
            x_we = pop_data.op == OP_WR_INPUT;
         end
         w_wa = pop_data.index[KA_W-1:0];
         w_wd = pop_data.value;
         x_wa = pop_data.index[PA_W-1:0];
         x_wd = pop_data.value;
      end else if (s2_v_ff) begin
         ig_wa = s2_xi_ff;
         wg_wa = s2_wi_ff;
         w_wa  = s2_wi_ff;
         priority case (op_ff)
            OP_ADD_GRAD: begin
               ig_we = 1'b1;
               ig_wd = sadd(s2_ig_ff, rnd_sat(WIDE_W'(pa_ff)));
               wg_we = 1'b1;
               wg_wd = sadd(s2_wg_ff, rnd_sat(WIDE_W'(pb_ff)));
            end
            OP_TRAIN: begin
               wg_we = 1'b1;
               w_we  = s2_wi_ff < cfg.nw;
               w_wd  = sat32(WIDE_W'(s2_w_ff) - WIDE_W'(rnd_sat(WIDE_W'(pa_ff))));
            end
            OP_RD_CLR_GRAD: ig_we = 1'b1;
            default: ;
         endcase
      end
   end

   cnvtr_ram #(.WIDTH(32), .DEPTH(KERNEL_DEPTH)) u_weight (
      .clock(clock), .wr_en(w_we), .wr_addr(w_wa), .wr_data(w_wd),
      .rd_addr(wi_ff), .rd_data(w_rd));
   cnvtr_ram #(.WIDTH(32), .DEPTH(PLANE_DEPTH)) u_input (
      .clock(clock), .wr_en(x_we), .wr_addr(x_wa), .wr_data(x_wd),
      .rd_addr(xi_s0), .rd_data(x_rd));
   cnvtr_ram #(.WIDTH(32), .DEPTH(KERNEL_DEPTH)) u_wgrad (
      .clock(clock), .wr_en(wg_we), .wr_addr(wg_wa), .wr_data(wg_wd),
      .rd_addr(wi_ff), .rd_data(wg_rd));
   cnvtr_ram #(.WIDTH(32), .DEPTH(PLANE_DEPTH)) u_igrad (
      .clock(clock), .wr_en(ig_we), .wr_addr(ig_wa), .wr_data(ig_wd),
      .rd_addr(xi_s0), .rd_data(ig_rd));

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_value = rsp_value_ff;
   assign rsp_ch.status       = rsp_status_ff;

   a_s2_follows_s1: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff |-> $past(s1_v_ff))
      else $error("product stage without read stage");
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !s1_v_ff && !s2_v_ff)
      else $error("pipeline busy while taking a new command");
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !s1_v_ff && !s2_v_ff && !rsp_valid_ff)
      else $error("activity during store clearing");
endmodule

// ===== rtl/conv2d_layer_train_engine.sv =====
// Top level of the convolution layer training engine.
// Depends on cnvtr_pkg, cnvtr_if, cnvtr_front, cnvtr_fifo, cnvtr_back.
//
// Channels: req_ch carries opcode/index/value requests, rsp_ch returns one
// result_value/status per request in order, csr_ch writes the six layout and
// rate registers (always ready; write only while no request is in flight).
// A request is taken when valid and ready are high at a clock edge.
// After a register write, req_ch.ready drops for one cycle.
// Path per request, from queue head to response register:
//   writes, errors, opcodes 6 and 7: straight to the response register
//   read-clear input gradient: a single tap
//   read output / add gradient: index decomposition (output channel, then
//   output column) plus in_channels*K*K taps on the shared multiplier
//   pipeline (100 taps at full size)
//   train: all 800 weight entries, one weight entry per cycle
// A two-entry queue lets the front accept requests while the back works.
// Reset (synchronous, active high) restores register defaults and then runs
// a clearing pass over all four stores; requests queue up but are
// not executed until it ends. A stalled rsp_ch holds its result and the back
// end waits; the front keeps filling the queue until it is full.
module conv2d_layer_train_engine (
   input  logic        clock,
   input  logic        reset,
   cnvtr_req_if.sink   req_ch,
   cnvtr_rsp_if.source rsp_ch,
   cnvtr_csr_if.sink   csr_ch
);
   import cnvtr_pkg::*;

   logic    push_valid, push_ready, pop_valid, pop_ready;
   cmd_type push_data, pop_data;
   cfg_type cfg;

   cnvtr_front u_front (
      .clock(clock), .reset(reset), .req_ch(req_ch), .csr_ch(csr_ch),
      .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
      .cfg(cfg));

   cnvtr_fifo u_fifo (
      .clock(clock), .reset(reset),
      .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data));

   cnvtr_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
      .rsp_ch(rsp_ch));
endmodule
